// File: hdl/battery_level_monitor_assert.svh
// assertion macros for the battery level monitor
`ifndef BATTERY_LEVEL_MONITOR_ASSERT_SVH
`define BATTERY_LEVEL_MONITOR_ASSERT_SVH

// property checked on every rising edge, off during reset
`define BLM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
		else $error("blm assertion failed");

// expression must never be true
`define BLM_ASSERT_NEVER(label, clk, rst_n, expr) \
	`BLM_ASSERT(label, clk, rst_n, !(expr))

`endif

// File: hdl/blm_pkg.sv
package blm_pkg;

	localparam int TIME_W     = 32;
	localparam int SENSE_W    = 12;
	localparam int RATIO_W    = 12;
	localparam int PROD_W     = SENSE_W + RATIO_W;
	localparam int MV_W       = 16;
	localparam int LEVEL_W    = 7;
	localparam int SPAN_W     = 10;
	localparam int RECIP_W    = 10;
	localparam int RECIP_SH   = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = 1;
	localparam int FIFO_CNT_W = 2;

	localparam logic [MV_W-1:0]    MV_MIN   = 16'd2500;
	localparam logic [MV_W-1:0]    MV_MAX   = 16'd5000;
	localparam logic [MV_W-1:0]    MV_EMPTY = 16'd3300;
	localparam logic [MV_W-1:0]    MV_FULL  = 16'd4200;
	// floor(d / 9) == floor(d * 100 / 900) for d < 900
	localparam logic [RECIP_W-1:0] RECIP_9  = 10'd911;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 7'd100;
	localparam logic [LEVEL_W-1:0] LEVEL_EMPTY = 7'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIVIDER_RATIO = 3'd0,
		CFG_LOW_LEVEL     = 3'd1,
		CFG_LOW_SLEEP_EN  = 3'd2,
		CFG_REPORT_IVL    = 3'd3,
		CFG_LOW_GRACE     = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		EV_LEVEL_REPORT = 1'b0,
		EV_SHUTDOWN     = 1'b1
	} event_kind_t;

	typedef struct packed {
		logic [RATIO_W-1:0] divider_ratio_q8;
		logic [LEVEL_W-1:0] low_level_pct;
		logic               low_sleep_enable;
		logic [TIME_W-1:0]  report_interval_ms;
		logic [TIME_W-1:0]  low_grace_ms;
	} cfg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               chg;
		logic [TIME_W-1:0]  now;
	} item_t;

	typedef struct packed {
		logic  push;
		item_t data;
	} push_t;

	typedef struct packed {
		logic  valid;
		item_t data;
	} head_t;

endpackage

// File: hdl/blm_front.sv
module blm_front
	import blm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SENSE_W-1:0]  sense_mv,
	input  logic                charging,
	input  logic [TIME_W-1:0]   now_ms,
	input  logic                q_full,
	output push_t               q_push
);

	logic                v1_s1, v2_s2, v3_s3;
	logic [PROD_W-1:0]   prod_s1;
	logic                chg_s1, chg_s2, chg_s3;
	logic [TIME_W-1:0]   now_s1, now_s2, now_s3;
	logic                ok_s2, ok_s3;
	logic                full_s2, empty_s2;
	logic [SPAN_W-1:0]   d_s2;
	logic [LEVEL_W-1:0]  level_s3;

	logic [MV_W-1:0]             mv;
	logic [MV_W-1:0]             d_wide;
	logic [SPAN_W+RECIP_W-1:0]   scaled;
	logic [LEVEL_W-1:0]          level_c;
	logic                        done_s3;

	assign in_ready = !(v1_s1 || v2_s2 || v3_s3);

	// product is at most 24 bits, so the 16-bit voltage never saturates
	assign mv     = prod_s1[PROD_W-1 -: MV_W];
	assign d_wide = mv - MV_EMPTY;
	assign scaled = SPAN_W'(d_s2) * RECIP_9;

	always_comb begin
		priority if (full_s2)
			level_c = LEVEL_FULL;
		else if (empty_s2)
			level_c = LEVEL_EMPTY;
		else
			level_c = scaled[RECIP_SH +: LEVEL_W];
	end

	// out-of-range readings are dropped here
	assign done_s3 = v3_s3 && (!ok_s3 || !q_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			v1_s1 <= in_valid && in_ready;
			v2_s2 <= v1_s1;
			if (v2_s2)
				v3_s3 <= 1'b1;
			else if (done_s3)
				v3_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prod_s1 <= PROD_W'(sense_mv) * PROD_W'(cfg.divider_ratio_q8);
			chg_s1  <= charging;
			now_s1  <= now_ms;
		end
		if (v1_s1) begin
			ok_s2    <= (mv >= MV_MIN) && (mv <= MV_MAX);
			full_s2  <= mv >= MV_FULL;
			empty_s2 <= mv <= MV_EMPTY;
			d_s2     <= d_wide[SPAN_W-1:0];
			chg_s2   <= chg_s1;
			now_s2   <= now_s1;
		end
		if (v2_s2) begin
			ok_s3    <= ok_s2;
			level_s3 <= level_c;
			chg_s3   <= chg_s2;
			now_s3   <= now_s2;
		end
	end

	assign q_push.push       = v3_s3 && ok_s3 && !q_full;
	assign q_push.data.level = level_s3;
	assign q_push.data.chg   = chg_s3;
	assign q_push.data.now   = now_s3;

endmodule

// File: hdl/blm_fifo.sv
module blm_fifo
	import blm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  push_t wr,
	output logic  full,
	input  logic  pop,
	output head_t head
);

	item_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_pop;

	assign full       = cnt_q == FIFO_CNT_W'(FIFO_DEPTH);
	assign head.valid = cnt_q != '0;
	assign head.data  = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr.push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr.push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !wr.push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.push)
			mem_q[wr_ptr_q] <= wr.data;
	end

endmodule

// File: hdl/blm_back.sv
module blm_back
	import blm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  head_t              head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output event_kind_t        out_kind,
	output logic [LEVEL_W-1:0] out_level,
	output logic               out_chg
);

	logic               halted_q;
	logic               low_timing_q;
	logic [TIME_W-1:0]  low_start_q;
	logic               last_valid_q;
	logic [LEVEL_W-1:0] last_level_q;
	logic               last_chg_q;
	logic [TIME_W-1:0]  last_rep_q;
	logic               out_valid_q;
	event_kind_t        out_kind_q;
	logic [LEVEL_W-1:0] out_level_q;
	logic               out_chg_q;

	item_t             it;
	logic              take, low, shut, report;
	logic [TIME_W-1:0] start, low_el, rep_el;

	assign it   = head.data;
	assign pop  = head.valid && (!out_valid_q || out_ready);
	assign take = pop && !halted_q;

	always_comb begin
		low    = cfg.low_sleep_enable && (it.level < cfg.low_level_pct) && !it.chg;
		start  = low_timing_q ? low_start_q : it.now;
		low_el = it.now - start;
		shut   = low && (low_el >= cfg.low_grace_ms);
		rep_el = it.now - last_rep_q;
		report = !last_valid_q || (it.chg != last_chg_q) || (it.level != last_level_q)
			|| (rep_el >= cfg.report_interval_ms);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q     <= 1'b0;
			low_timing_q <= 1'b0;
			low_start_q  <= '0;
			last_valid_q <= 1'b0;
			last_chg_q   <= 1'b0;
			last_rep_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (take) begin
				low_timing_q <= low;
				if (low)
					low_start_q <= start;
				if (shut)
					halted_q <= 1'b1;
				else if (report) begin
					last_valid_q <= 1'b1;
					last_chg_q   <= it.chg;
					last_rep_q   <= it.now;
				end
			end
			if (take && (shut || report))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !shut && report)
			last_level_q <= it.level;
		if (take && (shut || report)) begin
			out_kind_q  <= shut ? EV_SHUTDOWN : EV_LEVEL_REPORT;
			out_level_q <= it.level;
			out_chg_q   <= shut ? 1'b0 : it.chg;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_level = out_level_q;
	assign out_chg   = out_chg_q;

endmodule

// File: hdl/battery_level_monitor.sv
// Path: a sample's result passes the front end, the queue and the registered output
//   slot. The three-stage front end (divider multiply, range check, level scaling)
//   holds one sample at a time, keeps an in-range result in its last stage while the
//   queue is full, and takes the next beat the cycle after its last stage hands over.
// Reset (arst_n low): queue, output slot, report and grace-timer state clear;
//   config registers return to their defaults. No clearing pass.
module battery_level_monitor
	import blm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [47:0]           s_tdata,  // sense_mv[11:0], charging[12], now_ms[44:13]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,  // level_pct[6:0], charging_out[7]
	output logic                  m_tuser   // event_kind
);

	cfg_t               cfg_q;
	push_t              q_push;
	head_t              q_head;
	logic               q_full, q_pop;
	event_kind_t        kind;
	logic [LEVEL_W-1:0] level;
	logic               chg_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.divider_ratio_q8   <= 12'd512;
			cfg_q.low_level_pct      <= 7'd10;
			cfg_q.low_sleep_enable   <= 1'b1;
			cfg_q.report_interval_ms <= 32'd30000;
			cfg_q.low_grace_ms       <= 32'd60000;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_DIVIDER_RATIO: cfg_q.divider_ratio_q8   <= cfg_wdata[RATIO_W-1:0];
				CFG_LOW_LEVEL:     cfg_q.low_level_pct      <= cfg_wdata[LEVEL_W-1:0];
				CFG_LOW_SLEEP_EN:  cfg_q.low_sleep_enable   <= cfg_wdata[0];
				CFG_REPORT_IVL:    cfg_q.report_interval_ms <= cfg_wdata[TIME_W-1:0];
				CFG_LOW_GRACE:     cfg_q.low_grace_ms       <= cfg_wdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	blm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sense_mv (s_tdata[SENSE_W-1:0]),
		.charging (s_tdata[SENSE_W]),
		.now_ms   (s_tdata[SENSE_W+1 +: TIME_W]),
		.q_full   (q_full),
		.q_push   (q_push)
	);

	blm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.full   (q_full),
		.pop    (q_pop),
		.head   (q_head)
	);

	blm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (q_head),
		.pop       (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (kind),
		.out_level (level),
		.out_chg   (chg_out)
	);

	assign m_tdata = {chg_out, level};
	assign m_tuser = kind;

endmodule

// File: hdl/blm_checker.sv
`include "battery_level_monitor_assert.svh"

module blm_checker
	import blm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [7:0]            m_tdata,
	input logic                  m_tuser
);

	// nothing follows a shutdown beat
	`BLM_ASSERT(a_halt_quiet, clk, arst_n,
		(m_tvalid && m_tready && m_tuser == EV_SHUTDOWN) |=> !m_tvalid)

	// shutdown only happens while not charging
	`BLM_ASSERT_NEVER(a_shut_chg, clk, arst_n,
		m_tvalid && m_tuser == EV_SHUTDOWN && m_tdata[7])

	`BLM_ASSERT_NEVER(a_level_range, clk, arst_n,
		m_tvalid && (m_tdata[6:0] > LEVEL_FULL))

	// front end holds one sample at a time
	`BLM_ASSERT(a_one_in_flight, clk, arst_n,
		(s_tvalid && s_tready) |=> !s_tready)

	`BLM_ASSERT(a_out_hold, clk, arst_n,
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))

endmodule

bind battery_level_monitor blm_checker u_blm_checker (.*);
